FILE: hw/rtl/fcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcr_pkg: shared types and constants of the framed command receiver
// Byte markers, command codes, the frame phase type and the result record.
// ----------------------------------------------------------------------------
package fcr_pkg;

  localparam logic [7:0]  START_MARK  = 8'hFA;
  localparam logic [7:0]  CR_MARK     = 8'h0D;
  localparam logic [7:0]  LF_MARK     = 8'h0A;
  localparam logic [15:0] CMD_LED_ON  = 16'h1101;
  localparam logic [15:0] CMD_LED_OFF = 16'h1102;

  typedef enum logic [1:0] {
    PH_COLLECT  = 2'd0,
    PH_AWAIT_LF = 2'd1
  } phase_t;

  typedef struct packed {
    logic        frame_done;
    logic [15:0] command_word;
    logic        led_on;
    logic [3:0]  bytes_held;
  } result_t;

endpackage : fcr_pkg
`default_nettype wire

FILE: hw/rtl/fcr_frame.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcr_frame: frame state and per-byte update
// Holds the phase, byte buffer, latched command and LED state, and computes
// the result of one received byte; the state advances when step is high.
// ----------------------------------------------------------------------------
module fcr_frame #(
  parameter int BUFFER_BYTES = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic [7:0]       rx_byte,
  output fcr_pkg::result_t      res
);
  import fcr_pkg::*;

  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam int IW = $clog2(BUFFER_BYTES);
  localparam logic [CW-1:0] FULL = CW'(BUFFER_BYTES);

  phase_t            phase_r, phase_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [7:0]        store_r   [BUFFER_BYTES];
  logic [7:0]        store_nxt [BUFFER_BYTES];
  logic [15:0]       cmd_r, cmd_nxt;
  logic              led_r, led_nxt;
  logic              done;
  logic              clear;
  logic [IW-1:0]     wr_idx;
  logic [7:0]        first_byte;
  logic [CW+3:0]     fill_ext;

  assign wr_idx = fill_r[IW-1:0];

  // Phase: a carriage return arms the line-feed check, and the following
  // byte always returns to collecting.
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_COLLECT: begin
        if (rx_byte == CR_MARK) begin
          phase_nxt = PH_AWAIT_LF;
        end
      end
      PH_AWAIT_LF: phase_nxt = PH_COLLECT;
      default:     phase_nxt = PH_COLLECT;
    endcase
  end

  always_comb begin
    store_nxt  = store_r;
    fill_nxt   = fill_r;
    cmd_nxt    = cmd_r;
    done       = 1'b0;
    clear      = 1'b0;
    first_byte = store_r[0];
    if (phase_r == PH_AWAIT_LF) begin
      fill_nxt = '0;
      if (rx_byte == LF_MARK) begin
        cmd_nxt = {store_r[2], store_r[3]};
        clear   = 1'b1;
        done    = 1'b1;
      end
    end else if (rx_byte == CR_MARK) begin
      fill_nxt = fill_r;
    end else if (fill_r >= FULL) begin
      fill_nxt = '0;
      clear    = 1'b1;
    end else begin
      store_nxt[wr_idx] = rx_byte;
      if (wr_idx == '0) begin
        first_byte = rx_byte;
      end
      // A frame whose first byte is not the start mark is thrown away.
      if (first_byte != START_MARK) begin
        fill_nxt = '0;
        clear    = 1'b1;
      end else begin
        fill_nxt = fill_r + CW'(1);
      end
    end
    if (clear) begin
      for (int i = 0; i < BUFFER_BYTES; i++) begin
        store_nxt[i] = 8'h00;
      end
    end

    led_nxt = led_r;
    if (cmd_nxt == CMD_LED_ON) begin
      led_nxt = 1'b1;
    end else if (cmd_nxt == CMD_LED_OFF) begin
      led_nxt = 1'b0;
    end

    fill_ext         = {4'b0000, fill_nxt};
    res.frame_done   = done;
    res.command_word = cmd_nxt;
    res.led_on       = led_nxt;
    res.bytes_held   = fill_ext[3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_COLLECT;
      fill_r  <= '0;
      cmd_r   <= '0;
      led_r   <= 1'b0;
      for (int i = 0; i < BUFFER_BYTES; i++) begin
        store_r[i] <= 8'h00;
      end
    end else if (step) begin
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      cmd_r   <= cmd_nxt;
      led_r   <= led_nxt;
      store_r <= store_nxt;
    end
  end

endmodule : fcr_frame
`default_nettype wire

FILE: hw/rtl/framed_command_receiver_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Latency: a result is valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the output register frees in the same
// cycle it is taken, so a new byte is accepted whenever out_ready is high.
// Reset (rst_n low, synchronous) returns to collecting with an empty,
// zeroed buffer, command 0 and the LED off; no result is pending.
// ----------------------------------------------------------------------------
// framed_command_receiver_unit: framed command receiver
// Collects 0xFA-started frames ended by CR LF, latches bytes 2 and 3 as a
// command and drives an LED from it; one result request per received byte.
// ----------------------------------------------------------------------------
module framed_command_receiver_unit #(
  parameter int BUFFER_BYTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_frame_done,
  output logic [15:0]      out_command_word,
  output logic             out_led_on,
  output logic [3:0]       out_bytes_held
);
  import fcr_pkg::*;

  logic    accept;
  logic    out_valid_r;
  result_t res;
  result_t res_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  fcr_frame #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_frame (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (accept),
    .rx_byte(in_rx_byte),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_done   = res_r.frame_done;
  assign out_command_word = res_r.command_word;
  assign out_led_on       = res_r.led_on;
  assign out_bytes_held   = res_r.bytes_held;

endmodule : framed_command_receiver_unit
`default_nettype wire

FILE: hw/rtl/fcr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcr_checker: port-level checks of the framed command receiver
// Watches the result channel and the relation between its fields.
// ----------------------------------------------------------------------------
module fcr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_frame_done,
  input wire logic [15:0] out_command_word,
  input wire logic        out_led_on,
  input wire logic [3:0]  out_bytes_held
);
  import fcr_pkg::*;

  // A stalled result request keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_command_word) &&
      $stable(out_frame_done) && $stable(out_led_on) && $stable(out_bytes_held))
    else $error("stalled result changed");

  // Nothing is pending right after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A completed frame leaves the buffer empty.
  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_bytes_held == 4'd0)
    else $error("bytes held after frame completion");

  a_led_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command_word == CMD_LED_ON |-> out_led_on)
    else $error("LED off with on command latched");

  a_led_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command_word == CMD_LED_OFF |-> !out_led_on)
    else $error("LED on with off command latched");

endmodule : fcr_checker

bind framed_command_receiver_unit fcr_checker u_fcr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_frame_done  (out_frame_done),
  .out_command_word(out_command_word),
  .out_led_on      (out_led_on),
  .out_bytes_held  (out_bytes_held)
);
`default_nettype wire

FILE: sim/tb_framed_command_receiver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_framed_command_receiver_unit: testbench of the framed command receiver
// Feeds received bytes through the request handshake, predicts each result
// with a behavioral copy of the frame parser, and compares every field of
// every result request. Directed frames come first, then random frames.
// ----------------------------------------------------------------------------
module tb_framed_command_receiver_unit;

  import fcr_pkg::*;

  localparam int FRAME_BYTES = 8;
  localparam int IDLE_PCT    = 14;

  typedef struct packed {
    logic       drain;
    logic [7:0] data;
  } pending_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_frame_done;
  logic [15:0] out_command_word;
  logic        out_led_on;
  logic [3:0]  out_bytes_held;

  pending_t byte_q[$];
  result_t  expected_q[$];
  int       bytes_sent = 0;
  int       error_count = 0;
  logic     pause_pending = 1'b0;
  logic     steady;

  // Behavioral state of the parser.
  phase_t      frame_phase = PH_COLLECT;
  int          fill_level = 0;
  logic [7:0]  frame_bytes [FRAME_BYTES];
  logic [15:0] held_command = 16'h0000;
  logic        led_state = 1'b0;

  framed_command_receiver_unit #(
    .BUFFER_BYTES(FRAME_BYTES)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_done   (out_frame_done),
    .out_command_word (out_command_word),
    .out_led_on       (out_led_on),
    .out_bytes_held   (out_bytes_held)
  );

  // Neither side idles inside this window of requests.
  assign steady = (bytes_sent >= 400) && (bytes_sent < 800);

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic clear_frame();
    for (int i = 0; i < FRAME_BYTES; i++) frame_bytes[i] = 8'h00;
  endtask

  task automatic parse_byte(input logic [7:0] rx);
    result_t res;
    res.frame_done = 1'b0;
    if (frame_phase == PH_AWAIT_LF) begin
      frame_phase = PH_COLLECT;
      fill_level  = 0;
      if (rx == LF_MARK) begin
        held_command   = {frame_bytes[2], frame_bytes[3]};
        clear_frame();
        res.frame_done = 1'b1;
      end
    end else if (rx == CR_MARK) begin
      frame_phase = PH_AWAIT_LF;
    end else if (fill_level >= FRAME_BYTES) begin
      // The byte is dropped and the whole frame discarded.
      fill_level = 0;
      clear_frame();
    end else begin
      frame_bytes[fill_level] = rx;
      fill_level++;
      if (frame_bytes[0] != START_MARK) begin
        fill_level = 0;
        clear_frame();
      end
    end
    if (held_command == CMD_LED_ON) begin
      led_state = 1'b1;
    end else if (held_command == CMD_LED_OFF) begin
      led_state = 1'b0;
    end
    res.command_word = held_command;
    res.led_on       = led_state;
    res.bytes_held   = fill_level[3:0];
    expected_q.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      error_count++;
    end
  endtask

  function automatic void queue_byte(input logic [7:0] rx);
    pending_t item;
    item.data     = rx;
    item.drain    = pause_pending;
    pause_pending = 1'b0;
    byte_q.push_back(item);
  endfunction

  // A frame with data_len bytes after the start mark; positions 2 and 3 carry
  // the command. Lengths of the buffer size or more run into the overflow abort.
  task automatic queue_frame(input int data_len, input logic [15:0] cmd,
                             input logic [7:0] tail);
    logic [7:0] payload;
    queue_byte(START_MARK);
    for (int pos = 1; pos <= data_len; pos++) begin
      if (pos == 2) begin
        payload = cmd[15:8];
      end else if (pos == 3) begin
        payload = cmd[7:0];
      end else begin
        payload = 8'($urandom_range(255));
        if (payload == CR_MARK) payload = payload ^ 8'h40;
      end
      queue_byte(payload);
    end
    queue_byte(CR_MARK);
    queue_byte(tail);
  endtask

  // Request driver.
  always @(posedge clk) begin : drive_proc
    logic     next_valid;
    pending_t head;
    next_valid = in_valid;
    if (!rst_n) begin
      next_valid = 1'b0;
      frame_phase = PH_COLLECT;
      fill_level  = 0;
      held_command = 16'h0000;
      led_state    = 1'b0;
      clear_frame();
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(in_rx_byte);
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        next_valid = 1'b0;
        if (byte_q.size() != 0) begin
          head = byte_q[0];
          if (!(head.drain && expected_q.size() != 0) &&
              (steady || $urandom_range(99) >= IDLE_PCT)) begin
            void'(byte_q.pop_front());
            in_rx_byte <= head.data;
            next_valid = 1'b1;
          end
        end
      end
    end
    in_valid <= next_valid;
  end

  // Result monitor.
  always @(posedge clk) begin : watch_proc
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result request with no expected result pending");
          error_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("frame_done", want.frame_done, out_frame_done);
          check_field("command_word", want.command_word, out_command_word);
          check_field("led_on", want.led_on, out_led_on);
          check_field("bytes_held", want.bytes_held, out_bytes_held);
        end
      end
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin : stim_proc
    int          roll;
    logic [15:0] cmd;
    logic        late_pause_done;
    late_pause_done = 1'b0;

    // Wrong start bytes at both extremes.
    queue_byte(8'h00);
    queue_byte(8'hFF);
    // Complete frame that turns the LED on.
    queue_frame(3, CMD_LED_ON, LF_MARK);
    // Frame aborted after CR; its bytes stay behind in the buffer.
    queue_frame(3, CMD_LED_OFF, 8'h55);
    // CR LF with an empty buffer latches the aborted frame's stale command, LED off.
    queue_byte(CR_MARK);
    queue_byte(LF_MARK);
    // Fill the buffer completely, then one byte too many.
    queue_byte(START_MARK);
    for (int k = 1; k < FRAME_BYTES; k++) queue_byte(8'(k));
    queue_byte(8'h80);

    pause_pending = 1'b1;
    while (byte_q.size() < 1525) begin
      roll = $urandom_range(99);
      case ($urandom_range(4))
        0: cmd = CMD_LED_ON;
        1: cmd = CMD_LED_OFF;
        default: cmd = 16'($urandom_range(16'hFFFF));
      endcase
      if (roll < 72) begin
        queue_frame($urandom_range(1, FRAME_BYTES - 1), cmd, LF_MARK);
      end else if (roll < 82) begin
        queue_frame($urandom_range(1, FRAME_BYTES - 1), cmd, 8'($urandom_range(255)));
      end else if (roll < 90) begin
        queue_frame($urandom_range(FRAME_BYTES, FRAME_BYTES + 2), cmd, LF_MARK);
      end else begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(255)));
      end
      if (!late_pause_done && byte_q.size() > 1000) begin
        pause_pending   = 1'b1;
        late_pause_done = 1'b1;
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #400_000;
    $display("FAILURE");
    $finish;
  end

endmodule : tb_framed_command_receiver_unit
